FILE: rtl/cuab_pkg.sv
// Shared types and constants for the two-letter arrangement unranking block.
// No dependencies; imported by the top level and the table builder.
package cuab_pkg;

  localparam int COUNT_W      = 6;
  localparam int RANK_W       = 61;
  localparam int MAX_EACH_DEF = 32;

  typedef struct packed {
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic [RANK_W-1:0]  rank;
  } cuab_in_t;

  typedef struct packed {
    logic letter_is_b;
    logic last;
  } cuab_out_t;

  // Table builder status and RAM strobes
  typedef struct packed {
    logic we;
    logic re;
    logic done;
  } fill_ctrl_t;

endpackage

FILE: rtl/combination_unrank_ab_string_top.sv
// Top level: lexicographic unranking of an arrangement of 'a' and 'b' letters.
// Depends on cuab_pkg, cuab_ram, cuab_fill.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall  | in_req  (count_a, count_b, rank)
//   out_    | output    | out_valid/out_stall| out_rsp (letter_is_b, last)
//
// After reset the table builder fills the binomial RAM; in_stall stays high throughout.
// One request: the sequencer accepts it, then per letter while both counts
//   are nonzero it does a RAM read, then the shared 61-bit compare/subtract;
//   once one count is used up, each letter is emitted without a read.
// A stalled output holds the sequencer; the next request is taken while the
//   last letter of the previous one still waits in the output register.
module combination_unrank_ab_string_top #(
  parameter int MAX_EACH = cuab_pkg::MAX_EACH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cuab_pkg::cuab_in_t  in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output cuab_pkg::cuab_out_t out_rsp
);
  import cuab_pkg::*;

  localparam int SIDE  = MAX_EACH + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SIDE);
  localparam logic [AW-1:0]      SIDE_A  = AW'(SIDE);
  localparam logic [COUNT_W-1:0] MAX_IN  = COUNT_W'(MAX_EACH);

  typedef enum logic [1:0] {S_FILL, S_IDLE, S_STEP, S_CMP} state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     la_r, la_nxt;
  logic [CW-1:0]     lb_r, lb_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              out_valid_r, out_valid_nxt;
  cuab_out_t         out_rsp_r, out_rsp_nxt;

  // table builder and RAM
  fill_ctrl_t        fill_ctrl;
  logic [AW-1:0]     fill_rd_addr, fill_wr_addr;
  logic [RANK_W-1:0] fill_wr_data;
  logic [RANK_W-1:0] ram_rd_data;
  logic [AW-1:0]     ram_rd_addr, seq_rd_addr;
  logic              seq_rd_en;

  // sequencer helpers
  logic          slot_free, emit, emit_b;
  logic [CW-1:0] la_clamp, lb_clamp, la_after, lb_after;
  logic          rank_gt;
  logic [RANK_W-1:0] rank_diff;

  cuab_fill #(.MAX_EACH(MAX_EACH)) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_data (ram_rd_data),
    .ctrl    (fill_ctrl),
    .rd_addr (fill_rd_addr),
    .wr_addr (fill_wr_addr),
    .wr_data (fill_wr_data)
  );

  assign ram_rd_addr = fill_ctrl.done ? seq_rd_addr : fill_rd_addr;

  cuab_ram #(.WIDTH(RANK_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (fill_ctrl.we),
    .wr_addr (fill_wr_addr),
    .wr_data (fill_wr_data),
    .rd_en   (fill_ctrl.re | seq_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // counts above MAX_EACH saturate
  assign la_clamp = (in_req.count_a > MAX_IN) ? CW'(MAX_EACH) : in_req.count_a[CW-1:0];
  assign lb_clamp = (in_req.count_b > MAX_IN) ? CW'(MAX_EACH) : in_req.count_b[CW-1:0];

  // completions starting with 'a' live at entry [la-1][lb]
  assign seq_rd_addr = (AW'(la_r) - AW'(1)) * SIDE_A + AW'(lb_r);

  // shared compare/subtract: rank > count means letter 'b'
  assign rank_gt   = rank_r > ram_rd_data;
  assign rank_diff = rank_r - ram_rd_data;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    rank_nxt      = rank_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    seq_rd_en     = 1'b0;
    emit          = 1'b0;
    emit_b        = 1'b0;

    unique case (state_r)
      S_FILL: begin
        if (fill_ctrl.done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          la_nxt   = la_clamp;
          lb_nxt   = lb_clamp;
          rank_nxt = in_req.rank;
          if ((la_clamp != '0) || (lb_clamp != '0)) begin
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        if ((la_r != '0) && (lb_r != '0)) begin
          seq_rd_en = 1'b1;
          state_nxt = S_CMP;
        end else if (slot_free) begin
          // one letter used up: the rest is the other letter
          emit   = 1'b1;
          emit_b = (la_r == '0);
        end
      end
      S_CMP: begin
        if (slot_free) begin
          emit   = 1'b1;
          emit_b = rank_gt;
          if (rank_gt) begin
            rank_nxt = rank_diff;
          end
          state_nxt = S_STEP;
        end
      end
      default: state_nxt = S_FILL;
    endcase

    la_after = (emit && !emit_b) ? la_r - CW'(1) : la_r;
    lb_after = (emit &&  emit_b) ? lb_r - CW'(1) : lb_r;

    if (emit) begin
      la_nxt                  = la_after;
      lb_nxt                  = lb_after;
      out_valid_nxt           = 1'b1;
      out_rsp_nxt.letter_is_b = emit_b;
      out_rsp_nxt.last        = (la_after == '0) && (lb_after == '0);
      if (out_rsp_nxt.last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      out_valid_r <= 1'b0;
      la_r        <= '0;
      lb_r        <= '0;
      rank_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      la_r        <= la_nxt;
      lb_r        <= lb_nxt;
      rank_r      <= rank_nxt;
    end
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // table is built once per reset
  a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FILL) |=> (state_r != S_FILL))
    else $error("sequencer returned to table build");

  // a compare step only runs with both letters still pending
  a_cmp_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ((la_r != '0) && (lb_r != '0)))
    else $error("compare step with an exhausted count");

  // an empty request leaves the block ready in the next cycle
  a_empty_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req.count_a == '0) && (in_req.count_b == '0))
    |=> !in_stall)
    else $error("empty request did not finish at once");

  // table reads never go out of range during unranking
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_rd_en |-> (seq_rd_addr < AW'(DEPTH)))
    else $error("table read beyond depth");

endmodule

FILE: rtl/cuab_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cuab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/cuab_fill.sv
// Builds the Pascal table C(i+j, i) in RAM after reset, each entry in a read phase then a write phase.
// Depends on cuab_pkg.
module cuab_fill #(
  parameter int MAX_EACH = cuab_pkg::MAX_EACH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [cuab_pkg::RANK_W-1:0]                   rd_data,
  output cuab_pkg::fill_ctrl_t                          ctrl,
  output logic [$clog2((MAX_EACH+1)*(MAX_EACH+1))-1:0]  rd_addr,
  output logic [$clog2((MAX_EACH+1)*(MAX_EACH+1))-1:0]  wr_addr,
  output logic [cuab_pkg::RANK_W-1:0]                   wr_data
);
  import cuab_pkg::*;

  localparam int SIDE  = MAX_EACH + 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SIDE);
  localparam logic [AW-1:0] SIDE_A = AW'(SIDE);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_EACH);

  logic [AW-1:0]     addr_r, addr_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic              ph_r, ph_nxt;
  logic              done_r, done_nxt;
  logic [RANK_W-1:0] prev_r, prev_nxt;
  logic [RANK_W-1:0] above, left_v, sum;

  always_comb begin
    above   = (row_r != '0) ? rd_data : '0;
    left_v  = (col_r != '0) ? prev_r : '0;
    sum     = above + left_v + RANK_W'((row_r == '0) && (col_r == '0));

    addr_nxt = addr_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    ph_nxt   = ph_r;
    done_nxt = done_r;
    prev_nxt = prev_r;
    ctrl.we  = 1'b0;
    ctrl.re  = 1'b0;
    ctrl.done = done_r;

    if (!done_r) begin
      if (!ph_r) begin
        // fetch the entry one row up
        ctrl.re = (row_r != '0);
        ph_nxt  = 1'b1;
      end else begin
        ctrl.we  = 1'b1;
        prev_nxt = sum;
        ph_nxt   = 1'b0;
        addr_nxt = addr_r + AW'(1);
        if (col_r == MAX_C) begin
          col_nxt = '0;
          row_nxt = row_r + CW'(1);
        end else begin
          col_nxt = col_r + CW'(1);
        end
        if (addr_r == LAST_A) begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  assign rd_addr = addr_r - SIDE_A;
  assign wr_addr = addr_r;
  assign wr_data = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
    prev_r <= prev_nxt;
  end

endmodule
